// ===== rtl/seqstat_pkg.sv =====
// ----------------------------------------------------------------------------
// seqstat_pkg: shared types and constants
// Control word for the sample cell chain and fixed port widths.
// ----------------------------------------------------------------------------
package seqstat_pkg;

	// fixed port field widths
	localparam int SAMPLE_W    = 16;
	localparam int RUN_W       = 9;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 64;

	// run length saturates here
	localparam logic [RUN_W-1:0] RUN_LIMIT = 9'd511;

	// chain operation for the current cycle
	typedef struct packed {
		logic load;   // shift a new sample in at cell 0
		logic setup;  // copy own value to token, clear hit count
		logic scan;   // compare and rotate tokens around the ring
		logic drain;  // shift value and hits toward the tail
	} ctl_t;

endpackage

// ===== rtl/sequence_statistics_core.sv =====
// ----------------------------------------------------------------------------
// sequence_statistics_core: max, min, mode and longest rising run of a set
// Samples stream in; the word with tlast closes the set and yields one result.
// ----------------------------------------------------------------------------
// Each sample word is taken while the core is idle and shifted into a chain
// of MAX_SAMPLES cells while max, min and the rising run update on the fly.
// After the tlast word the chain runs a setup step, then rotates every stored
// value past every cell to count matches, then drains the counts to the mode
// picker, and the output register is filled once it is free. No sample is
// taken during the setup, scan, drain and done states. Samples past
// MAX_SAMPLES are dropped and flagged. The result register holds until taken;
// a new set may load while it waits.
module sequence_statistics_core #(
	parameter int MAX_SAMPLES = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_axis_tdata: [15:0] sample
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [seqstat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                                 s_axis_tlast,
	// m_axis_tdata: [15:0] largest, [31:16] smallest, [47:32] most_frequent,
	// [56:48] rising_run, [57] overflowed, [63:58] zero
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [seqstat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int HIT_W = CNT_W;
	localparam int STEP_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int RAW_W = (SAMPLE_BITS > seqstat_pkg::SAMPLE_W) ?
		SAMPLE_BITS : seqstat_pkg::SAMPLE_W;
	localparam int RUN_W = seqstat_pkg::RUN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [STEP_W-1:0]        step_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SAMPLE_BITS-1:0] max_q, min_q, prev_q, mode_q;
	logic [RUN_W-1:0]         cur_run_q, best_run_q;
	logic                     ovf_q;
	logic [HIT_W-1:0]         best_hits_q;

	logic                     in_fire;
	logic                     full;
	logic                     out_free;
	logic                     last_step;
	logic [RAW_W-1:0]         raw_ext;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic [RUN_W-1:0]         next_run;
	seqstat_pkg::ctl_t        ctl;
	logic [SAMPLE_BITS-1:0]   tail_val;
	logic [HIT_W-1:0]         tail_hits;
	logic                     tail_valid;
	logic [RAW_W-1:0]         max_ext, min_ext, mode_ext;

	// low SAMPLE_BITS of the sample field, read as signed
	assign raw_ext = RAW_W'(s_axis_tdata[seqstat_pkg::SAMPLE_W-1:0]);
	assign smp     = $signed(raw_ext[SAMPLE_BITS-1:0]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == CNT_W'(MAX_SAMPLES));
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign last_step     = (step_q == STEP_W'(MAX_SAMPLES - 1));

	// rising run step with saturation
	always_comb begin
		if (smp > prev_q) begin
			next_run = (cur_run_q < seqstat_pkg::RUN_LIMIT) ?
				cur_run_q + RUN_W'(1) : cur_run_q;
		end else begin
			next_run = RUN_W'(1);
		end
	end

	// chain control word
	always_comb begin
		ctl       = '0;
		ctl.load  = in_fire && !full;
		ctl.setup = (state_q == ST_SETUP);
		ctl.scan  = (state_q == ST_SCAN);
		ctl.drain = (state_q == ST_DRAIN);
	end

	seqstat_chain #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.HIT_W       (HIT_W),
		.CNT_W       (CNT_W)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.count      (count_q),
		.sample_in  (smp),
		.tail_val   (tail_val),
		.tail_hits  (tail_hits),
		.tail_valid (tail_valid)
	);

	// values masked to SAMPLE_BITS, then cut to the 16-bit fields
	assign max_ext  = RAW_W'(unsigned'(max_q));
	assign min_ext  = RAW_W'(unsigned'(min_q));
	assign mode_ext = RAW_W'(unsigned'(mode_q));

	// mode picker at the chain tail: highest count, smallest value on ties
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			best_hits_q <= '0;
		end else if (state_q == ST_DRAIN && tail_valid &&
				(tail_hits > best_hits_q ||
				 (tail_hits == best_hits_q && $signed(tail_val) < mode_q))) begin
			best_hits_q <= tail_hits;
			mode_q      <= $signed(tail_val);
		end
	end

	// sequencer, running statistics and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			count_q       <= '0;
			max_q         <= '0;
			min_q         <= '0;
			prev_q        <= '0;
			cur_run_q     <= '0;
			best_run_q    <= '0;
			ovf_q         <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			// result taken; the done state reloads it itself
			if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							if (count_q == '0) begin
								max_q      <= smp;
								min_q      <= smp;
								cur_run_q  <= RUN_W'(1);
								best_run_q <= RUN_W'(1);
							end else begin
								if (smp > max_q) max_q <= smp;
								if (smp < min_q) min_q <= smp;
								cur_run_q <= next_run;
								if (next_run > best_run_q) best_run_q <= next_run;
							end
							prev_q  <= smp;
							count_q <= count_q + CNT_W'(1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					step_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (last_step) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DRAIN: begin
					if (last_step) begin
						step_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {
							6'd0,
							ovf_q,
							best_run_q,
							mode_ext[seqstat_pkg::SAMPLE_W-1:0],
							min_ext[seqstat_pkg::SAMPLE_W-1:0],
							max_ext[seqstat_pkg::SAMPLE_W-1:0]
						};
						count_q    <= '0;
						max_q      <= '0;
						min_q      <= '0;
						prev_q     <= '0;
						cur_run_q  <= '0;
						best_run_q <= '0;
						ovf_q      <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/seqstat_cell.sv =====
// ----------------------------------------------------------------------------
// seqstat_cell: one entry of the sample chain
// Holds one stored sample, a circulating token and a hit counter.
// ----------------------------------------------------------------------------
module seqstat_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int HIT_W       = 9,
	parameter int CNT_W       = 9,
	parameter int CELL_IDX    = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  seqstat_pkg::ctl_t      ctl,
	input  logic [CNT_W-1:0]       count,
	input  logic [SAMPLE_BITS-1:0] val_in,
	input  logic [SAMPLE_BITS-1:0] tok_in,
	input  logic                   tokv_in,
	input  logic [HIT_W-1:0]       hits_in,
	output logic [SAMPLE_BITS-1:0] val_q,
	output logic [SAMPLE_BITS-1:0] tok_q,
	output logic                   tokv_q,
	output logic [HIT_W-1:0]       hits_q
);

	logic own_v;
	logic hit;

	// entry holds a sample of the current set
	assign own_v = (CNT_W'(CELL_IDX) < count);
	assign hit   = own_v && tokv_q && (tok_q == val_q);

	// stored value, token and hit counter
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.drain) begin
			val_q <= val_in;
		end
		if (ctl.setup) begin
			tok_q  <= val_q;
			hits_q <= '0;
		end else if (ctl.scan) begin
			tok_q <= tok_in;
			if (hit) begin
				hits_q <= hits_q + HIT_W'(1);
			end
		end else if (ctl.drain) begin
			hits_q <= hits_in;
		end
	end

	// token valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokv_q <= 1'b0;
		end else if (ctl.setup) begin
			tokv_q <= own_v;
		end else if (ctl.scan || ctl.drain) begin
			tokv_q <= tokv_in;
		end
	end

endmodule

// ===== rtl/seqstat_chain.sv =====
// ----------------------------------------------------------------------------
// seqstat_chain: row of sample cells
// Shift-in store, token ring for match counting, drain toward the tail.
// ----------------------------------------------------------------------------
module seqstat_chain #(
	parameter int MAX_SAMPLES = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int HIT_W       = 9,
	parameter int CNT_W       = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  seqstat_pkg::ctl_t      ctl,
	input  logic [CNT_W-1:0]       count,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic [SAMPLE_BITS-1:0] tail_val,
	output logic [HIT_W-1:0]       tail_hits,
	output logic                   tail_valid
);

	logic [SAMPLE_BITS-1:0] val_w  [MAX_SAMPLES];
	logic [SAMPLE_BITS-1:0] tok_w  [MAX_SAMPLES];
	logic                   tokv_w [MAX_SAMPLES];
	logic [HIT_W-1:0]       hits_w [MAX_SAMPLES];

	// head cell: new sample on load, ring wrap on scan, empty on drain
	seqstat_cell #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.HIT_W       (HIT_W),
		.CNT_W       (CNT_W),
		.CELL_IDX    (0)
	) u_cell0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.count   (count),
		.val_in  (sample_in),
		.tok_in  (tok_w[MAX_SAMPLES-1]),
		.tokv_in (tokv_w[MAX_SAMPLES-1] && !ctl.drain),
		.hits_in ('0),
		.val_q   (val_w[0]),
		.tok_q   (tok_w[0]),
		.tokv_q  (tokv_w[0]),
		.hits_q  (hits_w[0])
	);

	// remaining cells take from their left neighbor
	for (genvar i = 1; i < MAX_SAMPLES; i++) begin : g_cell
		seqstat_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.HIT_W       (HIT_W),
			.CNT_W       (CNT_W),
			.CELL_IDX    (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.count   (count),
			.val_in  (val_w[i-1]),
			.tok_in  (tok_w[i-1]),
			.tokv_in (tokv_w[i-1]),
			.hits_in (hits_w[i-1]),
			.val_q   (val_w[i]),
			.tok_q   (tok_w[i]),
			.tokv_q  (tokv_w[i]),
			.hits_q  (hits_w[i])
		);
	end

	assign tail_val   = val_w[MAX_SAMPLES-1];
	assign tail_hits  = hits_w[MAX_SAMPLES-1];
	assign tail_valid = tokv_w[MAX_SAMPLES-1];

endmodule
